/* src/true_lru_replacement_assert.svh */
// Assertion helpers shared by the replacement-state RTL.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef TRUE_LRU_REPLACEMENT_ASSERT_SVH
`define TRUE_LRU_REPLACEMENT_ASSERT_SVH

// The property must hold at every sampled edge.
`define TLRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true.
`define TLRU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* src/tlru_pkg.sv */
package tlru_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_SETS_DEF = 1024;
  localparam int unsigned WAYS_DEF     = 16;

  // Field widths of the request and result beats.
  localparam int unsigned SET_INDEX_W  = 10;
  localparam int unsigned WAY_W        = 4;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 8;
  // Wide enough to compare a way number against any ways-in-use count.
  localparam int unsigned CMP_W        = 6;
  // Value of ways_in_use after reset, capped at WAYS.
  localparam int unsigned WAYS_RST     = 16;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_TOUCH  = 1'b1
  } tlru_op_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_ACCESS
  } tlru_state_e;

  // Outcome of one request against a set row.
  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             bad_way;
    logic             row_we;
  } tlru_res_t;

endpackage

/* src/tlru_row_update.sv */
module tlru_row_update #(
  parameter int unsigned WAYS = tlru_pkg::WAYS_DEF,
  localparam int unsigned PW = $clog2(WAYS),
  localparam int unsigned NW = $clog2(WAYS + 1)
) (
  input  logic [WAYS-1:0][PW-1:0]      row_i,
  input  logic [NW-1:0]                n_i,
  input  tlru_pkg::tlru_op_e           op_i,
  input  logic [tlru_pkg::WAY_W-1:0]   way_i,
  output logic [WAYS-1:0][PW-1:0]      row_o,
  output tlru_pkg::tlru_res_t          res_o
);
  import tlru_pkg::*;

  logic            way_ok;
  logic [PW-1:0]   tw;
  logic [PW-1:0]   cur;
  logic [NW-1:0]   bottom;
  logic            found;
  logic [WAY_W-1:0] victim;

  assign way_ok = CMP_W'(way_i) < CMP_W'(n_i);
  assign tw     = PW'(way_i);
  assign cur    = row_i[tw];
  assign bottom = n_i - NW'(1);

  // Lowest-numbered way in use that sits at the bottom of the stack.
  always_comb begin
    found  = 1'b0;
    victim = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && (NW'(w) < n_i) && (NW'(row_i[w]) == bottom)) begin
        found  = 1'b1;
        victim = WAY_W'(w);
      end
    end
  end

  // Ways above the touched one in the stack move down by one.
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if ((NW'(w) < n_i) && (row_i[w] < cur)) begin
        row_o[w] = row_i[w] + PW'(1);
      end
    end
    row_o[tw] = '0;
  end

  always_comb begin
    res_o            = '0;
    res_o.victim_way = (op_i == OP_VICTIM) ? victim : '0;
    res_o.bad_way    = (op_i == OP_TOUCH) && !way_ok;
    res_o.row_we     = (op_i == OP_TOUCH) && way_ok;
  end

endmodule

/* src/true_lru_replacement.sv */
// Channel     | Dir | Beat contents
// s_axis_*    | in  | request: tuser = opcode, tdata = set_index, way
// m_axis_*    | out | result: tuser = bad_way, tdata = victim_way
// cfg_*       | in  | ways_in_use write, always ready
//
// A request: the accept cycle issues the set-row read, then the access step updates
// the row and, for a touch, writes it back through the single row memory.
// When NUM_SETS is below 1024 and not a power of two, a reciprocal-multiply
// stage folds the set index first, and the row read waits for the reduce step.
// After reset a clearing pass writes the initial row into every set, with
// s_axis_tready low.
// The result register lets a new request in while a result waits; a second
// finished result holds in the access step until the first is taken.
`include "true_lru_replacement_assert.svh"

module true_lru_replacement #(
  parameter int unsigned NUM_SETS = tlru_pkg::NUM_SETS_DEF,
  parameter int unsigned WAYS     = tlru_pkg::WAYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tlru_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // set_index[9:0], way[13:10]
  input  logic [0:0]                         s_axis_tuser,   // opcode[0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tlru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // victim_way[3:0]
  output logic [0:0]                         m_axis_tuser,   // bad_way[0]
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlru_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import tlru_pkg::*;

  localparam int unsigned PW       = $clog2(WAYS);
  localparam int unsigned NW       = $clog2(WAYS + 1);
  localparam int unsigned AW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SET_SPAN = 1 << SET_INDEX_W;
  localparam bit          POW2     = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam bit          DIRECT   = (NUM_SETS >= SET_SPAN) || POW2;
  localparam int unsigned RECIP_SH = 2 * SET_INDEX_W;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + NUM_SETS - 1) / NUM_SETS;
  localparam int unsigned RW       = $clog2(RECIP + 1);
  localparam int unsigned PROD_W   = SET_INDEX_W + RW;
  localparam int unsigned N_RST    = (WAYS < WAYS_RST) ? WAYS : WAYS_RST;

  typedef logic [WAYS-1:0][PW-1:0] row_t;

  tlru_state_e            state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          set_q, set_d;
  logic [NW-1:0]          n_q, n_d;
  tlru_op_e               op_q;
  logic [WAY_W-1:0]       way_q;
  logic                   out_valid_q;
  logic [WAY_W-1:0]       out_way_q;
  logic                   out_bad_q;
  logic                   out_load;

  logic [SET_INDEX_W-1:0] in_idx;
  logic [AW-1:0]          in_set;
  logic [AW-1:0]          red_set;
  logic                   accept;

  row_t                   row_mem [NUM_SETS];
  row_t                   rd_row_q;
  row_t                   rst_row;
  row_t                   upd_row;
  row_t                   mem_wdata;
  logic                   mem_re, mem_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  tlru_res_t              res;

  assign in_idx = s_axis_tdata[SET_INDEX_W-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;

  // Set index folding onto NUM_SETS.
  if (DIRECT) begin : g_direct
    if (NUM_SETS >= SET_SPAN) begin : g_wide
      assign in_set = AW'(in_idx);
    end else begin : g_mask
      assign in_set = AW'(in_idx & SET_INDEX_W'(NUM_SETS - 1));
    end
    assign red_set = set_q;
  end else begin : g_recip
    logic [PROD_W-1:0]      prod;
    logic [SET_INDEX_W-1:0] quo_q;
    logic [SET_INDEX_W-1:0] idx_q;

    // The reciprocal is exact for every 10-bit index, so no correction step.
    assign prod = PROD_W'(in_idx) * PROD_W'(RECIP);

    always_ff @(posedge clk_i) begin
      if (accept) begin
        quo_q <= SET_INDEX_W'(prod >> RECIP_SH);
        idx_q <= in_idx;
      end
    end

    assign red_set = AW'(idx_q - SET_INDEX_W'(quo_q * SET_INDEX_W'(NUM_SETS)));
    assign in_set  = '0;
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rst_row[w] = PW'(w);
    end
  end

  tlru_row_update #(
    .WAYS (WAYS)
  ) u_row_update (
    .row_i (rd_row_q),
    .n_i   (n_q),
    .op_i  (op_q),
    .way_i (way_q),
    .row_o (upd_row),
    .res_o (res)
  );

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    set_d         = set_q;
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_raddr     = in_set;
    mem_waddr     = set_q;
    mem_wdata     = upd_row;
    out_load      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = rst_row;
        clr_d     = AW'(clr_q + 1'b1);
        if (clr_q == AW'(NUM_SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (DIRECT) begin
            mem_re  = 1'b1;
            set_d   = in_set;
            state_d = S_ACCESS;
          end else begin
            state_d = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        mem_re    = 1'b1;
        mem_raddr = red_set;
        set_d     = red_set;
        state_d   = S_ACCESS;
      end
      S_ACCESS: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          mem_we   = res.row_we;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_d = NW'(1);
    end else if (CMP_W'(cfg_wdata_i) > CMP_W'(WAYS)) begin
      n_d = NW'(WAYS);
    end else begin
      n_d = NW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      set_q       <= '0;
      n_q         <= NW'(N_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      set_q       <= set_d;
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      if (cfg_valid_i) begin
        n_q <= n_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= tlru_op_e'(s_axis_tuser[0]);
      way_q <= s_axis_tdata[SET_INDEX_W +: WAY_W];
    end
    if (out_load) begin
      out_way_q <= res.victim_way;
      out_bad_q <= res.bad_way;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_row_q <= row_mem[mem_raddr];
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_way_q);
  assign m_axis_tuser  = out_bad_q;

  `TLRU_ASSERT_NEVER(a_rw_overlap, mem_re && mem_we,
                     "row read and row write in the same cycle")
  `TLRU_ASSERT(a_accept_next, accept |=> (state_q == S_ACCESS || state_q == S_REDUCE),
               "accepted request did not move on to the row access")
  `TLRU_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == S_ACCESS,
               "result appeared without a row access")
  `TLRU_ASSERT(a_stall_hold,
               (state_q == S_ACCESS && out_valid_q && !m_axis_tready) |=> state_q == S_ACCESS,
               "finished request left the access step while the result was stalled")
  `TLRU_ASSERT(a_write_touch, (state_q == S_ACCESS && mem_we) |-> op_q == OP_TOUCH,
               "row written back for a victim request")

endmodule
